@@ hw/rtl/rlr_pkg.sv @@
`default_nettype none

package rlr_pkg;

  localparam int unsigned ChW = 8;

  localparam logic [ChW-1:0] ChZero   = 8'h30;  // '0'
  localparam logic [ChW-1:0] ChNine   = 8'h39;  // '9'
  localparam logic [ChW-1:0] ChPeriod = 8'h2E;  // '.'
  localparam logic [ChW-1:0] ChExpUp  = 8'h45;  // 'E'
  localparam logic [ChW-1:0] ChExpLo  = 8'h65;  // 'e'
  localparam logic [ChW-1:0] ChMinus  = 8'h2D;  // '-'
  localparam logic [ChW-1:0] ChPlus   = 8'h2B;  // '+'

  typedef enum logic [1:0] {
    FormReject = 2'd0,
    FormPeriod = 2'd1,
    FormExp    = 2'd2,
    FormBoth   = 2'd3
  } form_e;

  // running scan flags for the lexeme in progress
  typedef struct packed {
    logic bad_seen;
    logic period_seen;
    logic exp_seen;
    logic mant_digit_seen;
    logic prev_was_exp;
    logic sign_seen;
    logic exp_digit_seen;
  } flags_t;

  typedef struct packed {
    logic  is_real;
    form_e form;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/rlr_in_stage.sv @@
`default_nettype none

module rlr_in_stage (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire [rlr_pkg::ChW-1:0] ch_i,
  input  wire                    last_i,
  input  wire                    out_free_i,
  output logic                   fire_o,
  output logic [rlr_pkg::ChW-1:0] ch_o,
  output logic                   last_o
);
  import rlr_pkg::*;

  logic           valid_q;
  logic [ChW-1:0] ch_q;
  logic           last_q;

  // a middle byte never needs the result slot; the final byte does
  assign fire_o     = valid_q && (!last_q || out_free_i);
  assign in_ready_o = !valid_q || fire_o;
  assign ch_o       = ch_q;
  assign last_o     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rlr_scan.sv @@
`default_nettype none

module rlr_scan (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     fire_i,
  input  wire [rlr_pkg::ChW-1:0]  ch_i,
  input  wire                     last_i,
  output rlr_pkg::result_t        result_o
);
  import rlr_pkg::*;

  flags_t flags_q, flags_d, nxt;
  logic   is_digit, is_period, is_exp, is_sign, ok;

  assign is_digit  = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign is_period = (ch_i == ChPeriod);
  assign is_exp    = (ch_i == ChExpUp) || (ch_i == ChExpLo);
  assign is_sign   = (ch_i == ChPlus) || (ch_i == ChMinus);

  always_comb begin
    nxt = flags_q;
    nxt.prev_was_exp = 1'b0;
    if (is_digit) begin
      if (flags_q.exp_seen) begin
        nxt.exp_digit_seen = 1'b1;
      end else begin
        nxt.mant_digit_seen = 1'b1;
      end
    end else if (is_period) begin
      if (flags_q.period_seen || flags_q.exp_seen) begin
        nxt.bad_seen = 1'b1;
      end
      nxt.period_seen = 1'b1;
    end else if (is_exp) begin
      if (flags_q.exp_seen || !flags_q.mant_digit_seen) begin
        nxt.bad_seen = 1'b1;
      end
      nxt.exp_seen     = 1'b1;
      nxt.prev_was_exp = 1'b1;
    end else if (is_sign) begin
      // sign only directly after the exponent letter
      if (!flags_q.prev_was_exp || flags_q.sign_seen) begin
        nxt.bad_seen = 1'b1;
      end
      nxt.sign_seen = 1'b1;
    end else begin
      nxt.bad_seen = 1'b1;
    end
  end

  assign ok = !nxt.bad_seen && nxt.mant_digit_seen && (nxt.period_seen || nxt.exp_seen) &&
              (!nxt.exp_seen || nxt.exp_digit_seen);

  always_comb begin
    result_o.is_real = ok;
    result_o.form    = ok ? form_e'({nxt.exp_seen, nxt.period_seen}) : FormReject;
  end

  // clear on the final byte for the next lexeme
  always_comb begin
    flags_d = flags_q;
    if (fire_i) begin
      flags_d = last_i ? '0 : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rlr_out_stage.sv @@
`default_nettype none

module rlr_out_stage (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    load_i,
  input  wire rlr_pkg::result_t  result_i,
  output logic                   out_free_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic                   is_real_o,
  output logic [1:0]             form_o
);
  import rlr_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign out_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign is_real_o   = result_q.is_real;
  assign form_o      = result_q.form;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/real_literal_recognizer_top.sv @@
`default_nettype none

// channel | valid      | ready      | payload
// in      | in_valid_i | in_ready_o | ch_i[7:0], last_i
// out     | out_valid_o| out_ready_i| is_real_o, form_o[1:0]
//
// One byte per cycle: an input register, one flag update step, a result register.
// A final byte's result loads the result register, which raises out_valid_o.
// Reset clears the flags and both valid bits; no clearing pass.
// in_ready_o drops only while a final byte waits in the input register
// for a result that is still untaken; any byte behind it waits as well.

module real_literal_recognizer_top (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire [rlr_pkg::ChW-1:0] ch_i,
  input  wire                    last_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic                   is_real_o,
  output logic [1:0]             form_o
);
  import rlr_pkg::*;

  logic           out_free;
  logic           fire;
  logic [ChW-1:0] ch_r;
  logic           last_r;
  result_t        result;

  rlr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .out_free_i (out_free),
    .fire_o     (fire),
    .ch_o       (ch_r),
    .last_o     (last_r)
  );

  rlr_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .ch_i     (ch_r),
    .last_i   (last_r),
    .result_o (result)
  );

  rlr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && last_r),
    .result_i    (result),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_real_o   (is_real_o),
    .form_o      (form_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import rlr_pkg::*;

  typedef logic [ChW-1:0] byte_q_t [$];

  localparam int unsigned CycleLimit = 250000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  logic [ChW-1:0] ch_i = '0;
  logic           last_i = 1'b0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  logic           is_real_o;
  logic [1:0]     form_o;

  flags_t    lex_flags = '0;
  result_t   expected_results [$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  int        cycle_count = 0;
  int        hold_request = 0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;

  real_literal_recognizer_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_real_o  (is_real_o),
    .form_o     (form_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Advance the scan flags by one byte; on the final byte queue the verdict and clear.
  task automatic predict_verdict(input logic [ChW-1:0] c, input logic fin);
    logic    after_exp;
    logic    ok;
    result_t res;
    after_exp = lex_flags.prev_was_exp;
    lex_flags.prev_was_exp = 1'b0;
    if (c >= ChZero && c <= ChNine) begin
      if (lex_flags.exp_seen) lex_flags.exp_digit_seen = 1'b1;
      else lex_flags.mant_digit_seen = 1'b1;
    end else if (c == ChPeriod) begin
      if (lex_flags.period_seen || lex_flags.exp_seen) lex_flags.bad_seen = 1'b1;
      lex_flags.period_seen = 1'b1;
    end else if (c == ChExpUp || c == ChExpLo) begin
      if (lex_flags.exp_seen || !lex_flags.mant_digit_seen) lex_flags.bad_seen = 1'b1;
      lex_flags.exp_seen = 1'b1;
      lex_flags.prev_was_exp = 1'b1;
    end else if (c == ChPlus || c == ChMinus) begin
      if (!after_exp || lex_flags.sign_seen) lex_flags.bad_seen = 1'b1;
      lex_flags.sign_seen = 1'b1;
    end else begin
      lex_flags.bad_seen = 1'b1;
    end
    if (fin) begin
      ok = !lex_flags.bad_seen && lex_flags.mant_digit_seen &&
           (lex_flags.period_seen || lex_flags.exp_seen) &&
           (!lex_flags.exp_seen || lex_flags.exp_digit_seen);
      res.is_real = ok;
      if (!ok) res.form = FormReject;
      else if (lex_flags.period_seen && lex_flags.exp_seen) res.form = FormBoth;
      else if (lex_flags.exp_seen) res.form = FormExp;
      else res.form = FormPeriod;
      expected_results.push_back(res);
      lex_flags = '0;
    end
  endtask

  task automatic send_word(input logic [ChW-1:0] c, input logic fin);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    predict_verdict(c, fin);
    bytes_sent++;
  endtask

  task automatic send_lexeme(input byte_q_t lex);
    for (int i = 0; i < lex.size(); i++) send_word(lex[i], i == lex.size() - 1);
  endtask

  function automatic logic [ChW-1:0] pick_digit();
    return ChZero + ChW'($urandom_range(0, 9));
  endfunction

  function automatic logic [ChW-1:0] pick_special();
    case ($urandom_range(0, 4))
      0: return ChPeriod;
      1: return ChExpUp;
      2: return ChExpLo;
      3: return ChMinus;
      default: return ChPlus;
    endcase
  endfunction

  function automatic byte_q_t make_well_formed();
    byte_q_t lex;
    int      int_n;
    int      frac_n;
    bit      has_period;
    bit      has_exp;
    int_n      = $urandom_range(0, 3);
    frac_n     = $urandom_range(0, 3);
    has_period = $urandom_range(0, 1);
    has_exp    = !has_period || ($urandom_range(0, 1) == 1);
    if (!has_period) frac_n = 0;
    if (int_n + frac_n == 0) int_n = 1;
    repeat (int_n) lex.push_back(pick_digit());
    if (has_period) begin
      lex.push_back(ChPeriod);
      repeat (frac_n) lex.push_back(pick_digit());
    end
    if (has_exp) begin
      lex.push_back($urandom_range(0, 1) ? ChExpUp : ChExpLo);
      case ($urandom_range(0, 2))
        0: lex.push_back(ChPlus);
        1: lex.push_back(ChMinus);
        default: ;
      endcase
      repeat ($urandom_range(1, 3)) lex.push_back(pick_digit());
    end
    return lex;
  endfunction

  // Mostly legal literals; the rest are corrupted literals, raw noise and symbol soup.
  function automatic byte_q_t make_lexeme();
    byte_q_t lex;
    int      pos;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: lex = make_well_formed();
      6, 7: begin
        lex = make_well_formed();
        pos = $urandom_range(0, lex.size() - 1);
        case ($urandom_range(0, 2))
          0: lex[pos] = $urandom_range(0, 1) ? pick_special() : ChW'($urandom_range(0, 255));
          1: lex.insert(pos, pick_special());
          default: begin
            if (lex.size() > 1) lex.delete(pos);
            else lex[pos] = pick_special();
          end
        endcase
      end
      8: repeat ($urandom_range(1, 4)) lex.push_back(ChW'($urandom_range(0, 255)));
      default: begin
        repeat ($urandom_range(1, 6))
          lex.push_back($urandom_range(0, 1) ? pick_digit() : pick_special());
      end
    endcase
    return lex;
  endfunction

  task automatic test_directed();
    string texts [$];
    string s;
    texts = '{"9.", "0E+9", ".5e-1", ".", "-1", "e5", "7", "1e"};
    foreach (texts[k]) begin
      s = texts[k];
      for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
    end
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_random_traffic(input int target);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (bytes_sent < target) send_lexeme(make_lexeme());
  endtask

  task automatic test_drain_pause();
    tx_idle_on = 1'b1;
    repeat (3) begin
      repeat (4) send_lexeme(make_lexeme());
      // hold the input idle until every verdict is out
      in_valid_i <= 1'b0;
      wait (expected_results.size() == 0);
      @(posedge clk_i);
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_request = 80;
    repeat (30) send_lexeme(make_lexeme());
  endtask

  task automatic test_streaming(input int count);
    int target;
    target     = bytes_sent + count;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (bytes_sent < target) send_lexeme(make_lexeme());
  endtask

  // receiver: draw a stall per word, or take a pending long hold-off
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 14) : 0;
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : check_verdicts
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("verdict with none expected");
      end else begin
        want = expected_results.pop_front();
        if (is_real_o !== want.is_real)
          report_mismatch($sformatf("is_real %b, want %b", is_real_o, want.is_real));
        if (form_o !== want.form)
          report_mismatch($sformatf("form %0d, want %0d", form_o, want.form));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(900);
    test_drain_pause();
    test_output_backpressure();
    test_streaming(250);
    in_valid_i <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
